// ===== src/assert_macros.svh =====
// assertion macros shared by the despreader rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication under reset
`define DBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbr assertion failed");
// next-cycle implication under reset
`define DBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbr assertion failed");
`else
`define DBR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DBR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/dbr_pkg.sv =====
// shared types and constants for the barker despreading receiver
// no dependencies; imported by every module of the block
package dbr_pkg;

    localparam int TAPS_DEF  = 32;
    localparam int DELAY_DEF = 16;
    localparam int SPS       = 44;
    localparam int SMP_W     = 12;
    localparam int TAP_W     = 16;
    localparam int TIDX_W    = 5;
    localparam int Y_W       = 16;
    localparam int ACC_W     = 24;
    localparam int POS_W     = 7;
    localparam int PROD_W    = SMP_W + TAP_W;
    localparam int DOT_W     = 2 * ACC_W + 1;
    localparam int RND_SH    = 14;
    localparam int QDEPTH    = 2;

    // barker chips, bit k set when chip k is +1
    localparam logic [10:0] BARKER_POS = 11'h0ED;

    localparam logic signed [ACC_W-1:0] START_REF = -24'sd44;
    localparam logic signed [ACC_W-1:0] RESET_REF = -24'sd1;

    typedef enum logic {
        OP_SAMPLE,
        OP_LOAD
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic                     pkt_start;
        logic signed [SMP_W-1:0]  smp_i;
        logic signed [SMP_W-1:0]  smp_q;
        logic [TIDX_W-1:0]        tap_idx;
        logic signed [TAP_W-1:0]  tap_val;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_DESPREAD,
        ST_DOT_MUL,
        ST_DOT_SUM
    } back_state_t;

    typedef struct packed {
        logic idle;
        logic emit;
    } back_stat_t;

endpackage

// ===== src/dbr_front.sv =====
// front end: takes input words, classifies them and pushes work to the queue
// depends on dbr_pkg
module dbr_front
    import dbr_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
)
(
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic                     packet_start,
    input  logic signed [SMP_W-1:0]  sample_i,
    input  logic signed [SMP_W-1:0]  sample_q,
    input  logic [TIDX_W-1:0]        tap_index,
    input  logic signed [TAP_W-1:0]  tap_value,
    input  logic                     q_full,
    output logic                     q_push,
    output op_t                      q_op
);

    logic in_range;
    logic keep;

    // loads beyond the tap count are taken and dropped
    assign in_range = int'(tap_index) < TAPS;
    assign keep     = !command || in_range;
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && keep;

    always_comb
    begin
        q_op.kind      = command ? OP_LOAD : OP_SAMPLE;
        q_op.pkt_start = packet_start;
        q_op.smp_i     = sample_i;
        q_op.smp_q     = sample_q;
        q_op.tap_idx   = tap_index;
        q_op.tap_val   = tap_value;
    end

endmodule

// ===== src/dbr_fifo.sv =====
// short work queue between front and back end
// depends on dbr_pkg
module dbr_fifo
    import dbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_push,
    input  op_t  q_op_in,
    output logic q_full,
    input  logic q_pop,
    output logic q_valid,
    output op_t  q_op_out
);

    localparam int PW = QDEPTH > 1 ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] PLAST = PW'(QDEPTH - 1);

    op_t           mem [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_full   = count_reg == CW'(QDEPTH);
    assign q_valid  = count_reg != '0;
    assign q_op_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PLAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PLAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !q_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem[wr_ptr_reg] <= q_op_in;
        end
    end

endmodule

// ===== src/dbr_back.sv =====
// back end: tap store, fir delay line, shared i/q mac, despreader and
// differential detector with output register; depends on dbr_pkg
module dbr_back
    import dbr_pkg::*;
#(
    parameter int TAPS  = TAPS_DEF,
    parameter int DELAY = DELAY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  op_t        q_op,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       decision_bit,
    output back_stat_t stat
);

    localparam int AW    = TAPS > 1 ? $clog2(TAPS) : 1;
    localparam int FW    = $clog2(TAPS + 1);
    localparam int SUM_W = PROD_W + FW;
    localparam int RW    = SUM_W + 1;
    localparam logic [AW-1:0]        LAST    = AW'(TAPS - 1);
    localparam logic [FW-1:0]        FTAPS   = FW'(TAPS);
    localparam logic [POS_W-1:0]     PDELAY  = POS_W'(DELAY);
    localparam logic [POS_W-1:0]     CLAST   = POS_W'(SPS - 1);
    localparam logic signed [RW-1:0] HALF    = RW'(1 << (RND_SH - 1));
    localparam logic signed [RW-1:0] SAT_MAX = RW'(32767);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(-32768);

    function automatic logic signed [Y_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [RW-1:0] ext;
        logic signed [RW-1:0] rnd;
        ext = {s[SUM_W-1], s};
        rnd = (ext + HALF) >>> RND_SH;
        if (rnd > SAT_MAX)
        begin
            round_sat = 16'sh7fff;
        end
        else if (rnd < SAT_MIN)
        begin
            round_sat = -16'sh8000;
        end
        else
        begin
            round_sat = rnd[Y_W-1:0];
        end
    endfunction

    logic signed [TAP_W-1:0]   tap_mem [TAPS];
    logic [2*SMP_W-1:0]        dl_mem  [TAPS];

    back_state_t               state_reg, state_next;
    logic [AW-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]             tap_addr_reg, tap_addr_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic [FW-1:0]             iss_cnt_reg, iss_cnt_next;
    logic                      s1_vld_reg, s1_vld_next;
    logic                      s1_live_reg, s1_live_next;
    logic [2*SMP_W-1:0]        dl_rd_reg;
    logic signed [TAP_W-1:0]   tap_rd_reg;
    logic                      s2_vld_reg, s2_vld_next;
    logic signed [PROD_W-1:0]  prod_i_reg, prod_i_next;
    logic signed [PROD_W-1:0]  prod_q_reg, prod_q_next;
    logic signed [SUM_W-1:0]   sum_i_reg, sum_i_next;
    logic signed [SUM_W-1:0]   sum_q_reg, sum_q_next;
    logic signed [Y_W-1:0]     y_i_reg, y_i_next;
    logic signed [Y_W-1:0]     y_q_reg, y_q_next;
    logic signed [ACC_W-1:0]   acc_i_reg, acc_i_next;
    logic signed [ACC_W-1:0]   acc_q_reg, acc_q_next;
    logic signed [ACC_W-1:0]   ref_i_reg, ref_i_next;
    logic signed [ACC_W-1:0]   ref_q_reg, ref_q_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic signed [2*ACC_W-1:0] dprod_i_reg, dprod_i_next;
    logic signed [2*ACC_W-1:0] dprod_q_reg, dprod_q_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      bit_reg, bit_next;

    logic                      tap_we;
    logic                      dl_we;
    logic                      emit;
    logic [POS_W-1:0]          chip_pos;
    logic signed [DOT_W-1:0]   dot;

    assign out_valid    = out_valid_reg;
    assign decision_bit = bit_reg;
    assign stat.idle    = state_reg == ST_IDLE;
    assign stat.emit    = emit;

    assign chip_pos = pos_reg - PDELAY;
    assign dot      = {dprod_i_reg[2*ACC_W-1], dprod_i_reg}
                    + {dprod_q_reg[2*ACC_W-1], dprod_q_reg};

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        tap_addr_next  = tap_addr_reg;
        fill_next      = fill_reg;
        iss_cnt_next   = iss_cnt_reg;
        s1_vld_next    = 1'b0;
        s1_live_next   = iss_cnt_reg < fill_reg;
        s2_vld_next    = s1_vld_reg;
        prod_i_next    = '0;
        prod_q_next    = '0;
        sum_i_next     = sum_i_reg;
        sum_q_next     = sum_q_reg;
        y_i_next       = y_i_reg;
        y_q_next       = y_q_reg;
        acc_i_next     = acc_i_reg;
        acc_q_next     = acc_q_reg;
        ref_i_next     = ref_i_reg;
        ref_q_next     = ref_q_reg;
        pos_next       = pos_reg;
        dprod_i_next   = dprod_i_reg;
        dprod_q_next   = dprod_q_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        tap_we         = 1'b0;
        dl_we          = 1'b0;
        emit           = 1'b0;

        if (s1_live_reg)
        begin
            prod_i_next = $signed(dl_rd_reg[2*SMP_W-1:SMP_W]) * tap_rd_reg;
            prod_q_next = $signed(dl_rd_reg[SMP_W-1:0]) * tap_rd_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_op.kind == OP_LOAD)
                    begin
                        tap_we = 1'b1;
                    end
                    else
                    begin
                        dl_we = 1'b1;
                        if (q_op.pkt_start)
                        begin
                            // older entries read as zero through the fill count
                            fill_next  = FW'(1);
                            acc_i_next = '0;
                            acc_q_next = '0;
                            ref_i_next = START_REF;
                            ref_q_next = START_REF;
                            pos_next   = '0;
                        end
                        else if (fill_reg != FTAPS)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        rd_ptr_next   = wr_ptr_reg;
                        wr_ptr_next   = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
                        tap_addr_next = LAST;
                        iss_cnt_next  = '0;
                        sum_i_next    = '0;
                        sum_q_next    = '0;
                        state_next    = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                if (iss_cnt_reg < FTAPS)
                begin
                    s1_vld_next   = 1'b1;
                    iss_cnt_next  = iss_cnt_reg + 1'b1;
                    rd_ptr_next   = (rd_ptr_reg == '0) ? LAST : rd_ptr_reg - 1'b1;
                    tap_addr_next = tap_addr_reg - 1'b1;
                end
                else if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = ST_ROUND;
                end
                if (s2_vld_reg)
                begin
                    sum_i_next = sum_i_reg + SUM_W'(prod_i_reg);
                    sum_q_next = sum_q_reg + SUM_W'(prod_q_reg);
                end
            end
            ST_ROUND:
            begin
                y_i_next   = round_sat(sum_i_reg);
                y_q_next   = round_sat(sum_q_reg);
                state_next = ST_DESPREAD;
            end
            ST_DESPREAD:
            begin
                state_next = ST_IDLE;
                if (pos_reg < PDELAY)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    if (BARKER_POS[chip_pos[5:2]])
                    begin
                        acc_i_next = acc_i_reg + ACC_W'(y_i_reg);
                        acc_q_next = acc_q_reg + ACC_W'(y_q_reg);
                    end
                    else
                    begin
                        acc_i_next = acc_i_reg - ACC_W'(y_i_reg);
                        acc_q_next = acc_q_reg - ACC_W'(y_q_reg);
                    end
                    if (chip_pos == CLAST)
                    begin
                        state_next = ST_DOT_MUL;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_DOT_MUL:
            begin
                dprod_i_next = ref_i_reg * acc_i_reg;
                dprod_q_next = ref_q_reg * acc_q_reg;
                state_next   = ST_DOT_SUM;
            end
            ST_DOT_SUM:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    bit_next       = dot[DOT_W-1] || (dot == '0);
                    ref_i_next     = acc_i_reg;
                    ref_q_next     = acc_q_reg;
                    acc_i_next     = '0;
                    acc_q_next     = '0;
                    pos_next       = PDELAY;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            tap_addr_reg  <= '0;
            fill_reg      <= '0;
            iss_cnt_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            s1_live_reg   <= 1'b0;
            s2_vld_reg    <= 1'b0;
            acc_i_reg     <= '0;
            acc_q_reg     <= '0;
            ref_i_reg     <= RESET_REF;
            ref_q_reg     <= RESET_REF;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            tap_addr_reg  <= tap_addr_next;
            fill_reg      <= fill_next;
            iss_cnt_reg   <= iss_cnt_next;
            s1_vld_reg    <= s1_vld_next;
            s1_live_reg   <= s1_live_next;
            s2_vld_reg    <= s2_vld_next;
            acc_i_reg     <= acc_i_next;
            acc_q_reg     <= acc_q_next;
            ref_i_reg     <= ref_i_next;
            ref_q_reg     <= ref_q_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_i_reg  <= prod_i_next;
        prod_q_reg  <= prod_q_next;
        sum_i_reg   <= sum_i_next;
        sum_q_reg   <= sum_q_next;
        y_i_reg     <= y_i_next;
        y_q_reg     <= y_q_next;
        dprod_i_reg <= dprod_i_next;
        dprod_q_reg <= dprod_q_next;
        bit_reg     <= bit_next;
    end

    // tap store and delay line, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[AW'(q_op.tap_idx)] <= q_op.tap_val;
        end
        tap_rd_reg <= tap_mem[tap_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[wr_ptr_reg] <= {q_op.smp_i, q_op.smp_q};
        end
        dl_rd_reg <= dl_mem[rd_ptr_reg];
    end

endmodule

// ===== src/dbpsk_barker_despread_receiver_unit.sv =====
// top level of the dbpsk barker-11 despreading receiver
// depends on dbr_pkg, dbr_front, dbr_fifo, dbr_back and assert_macros.svh
//
// channel  direction  handshake            payload
// in       to block   in_valid/in_stall    command packet_start sample_i sample_q
//                                          tap_index tap_value
// out      from block out_valid/out_stall  decision_bit
//
// a tap load word is written to the tap store from the idle state
// a sample word passes the mac, round and despread states, the i/q mac walking the taps
// a sample that closes a 44-sample window adds the dot product states and any wait on out
// a two-word queue lets the input keep moving while the back end works
// reset clears control state at once; the tap store is undefined until loaded
`include "assert_macros.svh"

module dbpsk_barker_despread_receiver_unit
    import dbr_pkg::*;
#(
    parameter int TAPS  = TAPS_DEF,
    parameter int DELAY = DELAY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic                     packet_start,
    input  logic signed [SMP_W-1:0]  sample_i,
    input  logic signed [SMP_W-1:0]  sample_q,
    input  logic [TIDX_W-1:0]        tap_index,
    input  logic signed [TAP_W-1:0]  tap_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     decision_bit
);

    // queue links between front and back end
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    op_t        push_op;
    op_t        head_op;
    back_stat_t back_stat;

    // front: classify words, drop out-of-range tap loads
    dbr_front #(
        .TAPS (TAPS)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .packet_start (packet_start),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .tap_index    (tap_index),
        .tap_value    (tap_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (push_op)
    );

    // work queue
    dbr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .q_op_in  (push_op),
        .q_full   (q_full),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_op_out (head_op)
    );

    // back: fir, despreading and differential decision
    dbr_back #(
        .TAPS  (TAPS),
        .DELAY (DELAY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_op         (head_op),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .decision_bit (decision_bit),
        .stat         (back_stat)
    );

    // a decision is only loaded when the output register is free
    `DBR_ASSERT_IMP(a_emit_free, clk, rst_n, back_stat.emit, !out_valid || !out_stall)
    // the back end only takes work while idle
    `DBR_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, back_stat.idle)
    // a loaded decision shows on the output next cycle
    `DBR_ASSERT_NEXT(a_emit_shows, clk, rst_n, back_stat.emit, out_valid)

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for dbpsk_barker_despread_receiver_unit
// drives sample and tap-load words, predicts each decision bit and checks it
// depends on dbr_pkg and the rtl of the block only
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dbr_pkg::*;

    localparam int TAPS          = TAPS_DEF;
    localparam int DELAY         = DELAY_DEF;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int QUIET_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 4 * (TAPS + 8);
    localparam int ROWS          = 20;

    // one input word plus an optional hand-worked decision for it
    typedef struct {
        op_t op;
        bit  pinned;
        bit  pinned_bit;
    } stim_word_t;

    // directed row: reps copies of one word, load index counting up
    typedef struct {
        op_kind_t kind;
        bit       start;
        int       si;
        int       sq;
        int       idx;
        int       val;
        int       reps;
        bit       pinned;
        bit       want;
    } plan_row_t;

    // receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_READY,
        RX_COIN,
        RX_SPARSE,
        RX_LONG
    } stall_mode_t;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic                    command      = 1'b0;
    logic                    packet_start = 1'b0;
    logic signed [SMP_W-1:0] sample_i     = '0;
    logic signed [SMP_W-1:0] sample_q     = '0;
    logic [TIDX_W-1:0]       tap_index    = '0;
    logic signed [TAP_W-1:0] tap_value    = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic                    decision_bit;

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    dbpsk_barker_despread_receiver_unit #(
        .TAPS  (TAPS),
        .DELAY (DELAY)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .packet_start (packet_start),
        .sample_i     (sample_i),
        .sample_q     (sample_q),
        .tap_index    (tap_index),
        .tap_value    (tap_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .decision_bit (decision_bit)
    );

    // ------------------------------------------------------------------
    // receiver model: fir, barker despreader and differential detector
    // ------------------------------------------------------------------
    logic signed [TAP_W-1:0] coef   [TAPS];
    logic signed [SMP_W-1:0] line_i [TAPS];
    logic signed [SMP_W-1:0] line_q [TAPS];
    int corr_i, corr_q;     // running despread sums of the open window
    int prev_i, prev_q;     // correlation of the last closed window
    int phase;              // samples since packet start, parked at DELAY

    // clears everything a packet start clears; refs are -1 after reset
    function automatic void restart_packet(input int seed_ref);
        for (int j = 0; j < TAPS; j++)
        begin
            line_i[j] = '0;
            line_q[j] = '0;
        end
        corr_i = 0;
        corr_q = 0;
        prev_i = seed_ref;
        prev_q = seed_ref;
        phase  = 0;
    endfunction

    // fir over one rail, round half up to q5.11 and clip to 16 bits
    function automatic int filter_rail(input bit use_q);
        longint sum;
        longint r;
        sum = 0;
        for (int j = 0; j < TAPS; j++)
            sum += longint'(use_q ? line_q[j] : line_i[j]) * longint'(coef[TAPS-1-j]);
        r = (sum + 64'sd8192) >>> RND_SH;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return int'(r);
    endfunction

    // consumes one accepted word; returns 1 when it closes a window
    function automatic bit advance_receiver(input op_t w, output bit decision);
        int     yi, yq, chip, c;
        longint dot;
        decision = 1'b0;
        if (w.kind == OP_LOAD)
        begin
            // packet start rides along on a load but is ignored
            if (int'(w.tap_idx) < TAPS)
                coef[w.tap_idx] = w.tap_val;
            return 1'b0;
        end
        if (w.pkt_start)
            restart_packet(int'(START_REF));
        for (int j = TAPS - 1; j > 0; j--)
        begin
            line_i[j] = line_i[j-1];
            line_q[j] = line_q[j-1];
        end
        line_i[0] = w.smp_i;
        line_q[0] = w.smp_q;
        yi = filter_rail(1'b0);
        yq = filter_rail(1'b1);
        // lead-in after packet start gives nothing
        if (phase < DELAY)
        begin
            phase++;
            return 1'b0;
        end
        c = phase - DELAY;
        if (c >= SPS)
            c = SPS - 1;
        chip = BARKER_POS[c / 4] ? 1 : -1;
        corr_i += yi * chip;
        corr_q += yq * chip;
        if (c != SPS - 1)
        begin
            phase++;
            return 1'b0;
        end
        // window closed: reversal when the dot product is not positive
        dot = longint'(prev_i) * longint'(corr_i) + longint'(prev_q) * longint'(corr_q);
        decision = (dot <= 0);
        prev_i = corr_i;
        prev_q = corr_q;
        corr_i = 0;
        corr_q = 0;
        phase  = DELAY;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    stim_word_t pending_words [$];      // words not yet offered
    bit         expected_decisions [$]; // decisions owed by the block
    int         words_queued       = 0;
    int         words_accepted     = 0;
    int         fail_count         = 0;
    int         quiet_cycles       = 0;

    task automatic push_word(input op_kind_t kind, input bit start, input int si,
                             input int sq, input int idx, input int val,
                             input bit pinned, input bit want);
        stim_word_t w;
        w.op.kind      = kind;
        w.op.pkt_start = start;
        w.op.smp_i     = si[SMP_W-1:0];
        w.op.smp_q     = sq[SMP_W-1:0];
        w.op.tap_idx   = idx[TIDX_W-1:0];
        w.op.tap_val   = val[TAP_W-1:0];
        w.pinned       = pinned;
        w.pinned_bit   = want;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // rewrite n taps; all of them in order when n covers the store
    task automatic reload_taps(input int n, input bit wide);
        int idx, val;
        for (int k = 0; k < n; k++)
        begin
            idx = (n == TAPS) ? k : int'($urandom_range(0, TAPS - 1));
            // wide values saturate the filter quickly, narrow ones keep it linear
            val = wide ? int'($urandom) : int'($urandom_range(0, 8192)) - 4096;
            push_word(OP_LOAD, 1'($urandom_range(0, 1)), $urandom, $urandom, idx, val,
                      1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // input side: bursts of words with random gaps, prediction on accept
    // ------------------------------------------------------------------
    stim_word_t cur_word;
    int         burst_left = 1;
    int         gap_left   = 0;

    always @(posedge clk)
    begin : drive_in
        bit decision, closes;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                closes = advance_receiver(cur_word.op, decision);
                // hand-worked rows override the model's value
                if (cur_word.pinned)
                    expected_decisions.push_back(cur_word.pinned_bit);
                else if (closes)
                    expected_decisions.push_back(decision);
                words_accepted++;
            end
            // payload is frozen while a word sits stalled
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    command      <= cur_word.op.kind;
                    packet_start <= cur_word.op.pkt_start;
                    sample_i     <= cur_word.op.smp_i;
                    sample_q     <= cur_word.op.smp_q;
                    tap_index    <= cur_word.op.tap_idx;
                    tap_value    <= cur_word.op.tap_val;
                    in_valid     <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 6);
                            default: gap_left = $urandom_range(7, 24);
                        endcase
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: stall pattern and decision check
    // ------------------------------------------------------------------
    stall_mode_t stall_mode = RX_READY;
    int          stall_left = 0;

    always @(posedge clk)
    begin : drive_out
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 200);
            end
            else
                stall_left--;
            case (stall_mode)
                RX_READY:  out_stall <= 1'b0;
                RX_COIN:   out_stall <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
                default:   out_stall <= ((stall_left % 61) > 12); // runs of stall broken by gaps
            endcase
        end
    end

    always @(posedge clk)
    begin : check_out
        bit want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_decisions.size() == 0)
            begin
                $error("decision_bit: unexpected word, actual %0b", decision_bit);
                fail_count++;
            end
            else
            begin
                want = expected_decisions.pop_front();
                if (decision_bit !== want)
                begin
                    $error("decision_bit: expected %0b, actual %0b", want, decision_bit);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $error("no word moved for %0d cycles, %0d decisions outstanding",
               QUIET_LIMIT, expected_decisions.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // directed plan: unit tap on the newest sample makes the filter a
    // wire, so a constant word gives a window correlation of 4x itself
    // ------------------------------------------------------------------
    plan_row_t plan [ROWS];

    initial
    begin : stimulus
        int random_start, len, pick, si, sq, sym_i, sym_q;
        bit coherent;

        restart_packet(int'(RESET_REF));
        plan = '{
            // every tap written before the first sample reads them
            '{OP_LOAD,   1'b0,     0,     0, 0,         0, TAPS - 1,      1'b0, 1'b0},
            '{OP_LOAD,   1'b0,     0,     0, TAPS - 1,  16384, 1,         1'b0, 1'b0},
            // no packet start since reset, references at -1
            '{OP_SAMPLE, 1'b0,   100,   100, 0,         0, DELAY + SPS,   1'b1, 1'b1},
            '{OP_SAMPLE, 1'b0,   100,   100, 0,         0, SPS,           1'b1, 1'b0},
            '{OP_SAMPLE, 1'b0,  -100,  -100, 0,         0, SPS,           1'b1, 1'b1},
            // equal negative pair against i/q extremes, dot is +176
            '{OP_SAMPLE, 1'b1,  2047, -2048, 0,         0, DELAY + SPS,   1'b1, 1'b0},
            // zero correlation, then zero reference: dot of zero counts as reversal
            '{OP_SAMPLE, 1'b0,     0,     0, 0,         0, SPS,           1'b1, 1'b1},
            '{OP_SAMPLE, 1'b0, -2048,  2047, 0,         0, SPS,           1'b1, 1'b1},
            // packet start on a load must not restart the window
            '{OP_LOAD,   1'b1,     0,     0, TAPS - 1, -16384, 1,         1'b0, 1'b0},
            '{OP_SAMPLE, 1'b0, -2048,  2047, 0,         0, SPS,           1'b1, 1'b1},
            // packet start in mid window and again inside the lead-in
            '{OP_SAMPLE, 1'b0,   500,  -500, 0,         0, 20,            1'b0, 1'b0},
            '{OP_SAMPLE, 1'b1,   300,   300, 0,         0, DELAY + SPS,   1'b1, 1'b0},
            '{OP_SAMPLE, 1'b1,    -7,     9, 0,         0, 5,             1'b0, 1'b0},
            // unit sample against the negative unit tap filters to -1
            '{OP_SAMPLE, 1'b1,     1,     1, 0,         0, DELAY + SPS,   1'b1, 1'b0},
            // most negative taps: filter clips high from the eighth sample on
            '{OP_LOAD,   1'b0,     0,     0, 0,    -32768, TAPS,          1'b0, 1'b0},
            '{OP_SAMPLE, 1'b1, -2048, -2048, 0,         0, DELAY + SPS,   1'b1, 1'b1},
            '{OP_SAMPLE, 1'b0,  2047,  2047, 0,         0, SPS,           1'b0, 1'b0},
            // most positive taps, both clip directions
            '{OP_LOAD,   1'b0,     0,     0, 0,     32767, TAPS,          1'b0, 1'b0},
            '{OP_SAMPLE, 1'b1,  2047, -2048, 0,         0, DELAY + 2*SPS, 1'b0, 1'b0},
            '{OP_SAMPLE, 1'b0, -2048,  2047, 0,         0, SPS,           1'b0, 1'b0}
        };

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
            for (int k = 0; k < plan[r].reps; k++)
                push_word(plan[r].kind, plan[r].start && (k == 0), plan[r].si, plan[r].sq,
                          plan[r].idx + k, plan[r].val,
                          plan[r].pinned && (k == plan[r].reps - 1), plan[r].want);

        // random part: mostly whole packets, some tap rewrites and loose noise
        reload_taps(TAPS, 1'b0);
        random_start = words_queued;
        while (words_queued - random_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                reload_taps($urandom_range(1, TAPS), $urandom_range(0, 3) == 0);
            else if (pick <= 8)
            begin
                // well-formed packet: lead-in, whole windows, sometimes a ragged tail
                len = DELAY + SPS * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    len += $urandom_range(1, SPS - 1);
                coherent = 1'($urandom_range(0, 1));
                sym_i = int'($urandom_range(0, 3000)) - 1500;
                sym_q = int'($urandom_range(0, 3000)) - 1500;
                for (int k = 0; k < len; k++)
                begin
                    // each symbol keeps or flips the carrier phase
                    if (k % SPS == 0 && $urandom_range(0, 1) == 1)
                    begin
                        sym_i = -sym_i;
                        sym_q = -sym_q;
                    end
                    if (coherent)
                    begin
                        si = sym_i + int'($urandom_range(0, 600)) - 300;
                        sq = sym_q + int'($urandom_range(0, 600)) - 300;
                    end
                    else
                    begin
                        si = $urandom;
                        sq = $urandom;
                    end
                    push_word(OP_SAMPLE, k == 0, si, sq, $urandom, $urandom, 1'b0, 1'b0);
                end
            end
            else
            begin
                // noise: samples with stray packet starts
                len = $urandom_range(1, 50);
                for (int k = 0; k < len; k++)
                    push_word(OP_SAMPLE, $urandom_range(0, 19) == 0, $urandom, $urandom,
                              $urandom, $urandom, 1'b0, 1'b0);
            end
            while (pending_words.size() > 8)
                @(posedge clk);
        end

        // drain: every word taken, every decision back, then a quiet tail
        while (words_accepted != words_queued)
            @(posedge clk);
        while (expected_decisions.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/dbr_pkg.sv
src/dbr_front.sv
src/dbr_fifo.sv
src/dbr_back.sv
src/dbpsk_barker_despread_receiver_unit.sv
verif/testbench.sv
